// File: hdl/sbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbb_pkg
// Shared types and constants of the spectrum bin ballistics block.
// ----------------------------------------------------------------------------
package sbb_pkg;

	localparam int NUM_BINS    = 64;
	localparam int LEVEL_BITS  = 16;
	localparam int BIN_W       = 6;
	localparam int ADDR_W      = $clog2(NUM_BINS);
	localparam int COEFF_W     = 16;
	localparam int PROD_W      = LEVEL_BITS + COEFF_W;
	localparam int ENTRY_W     = 3 * LEVEL_BITS;
	localparam int IN_TDATA_W  = ((BIN_W + LEVEL_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((BIN_W + 2 * LEVEL_BITS + 7) / 8) * 8;
	localparam int APB_AW      = 4;
	localparam int APB_DW      = 32;

	typedef logic [LEVEL_BITS-1:0] level_t;
	typedef logic [COEFF_W-1:0]    coeff_t;

	typedef struct packed {
		coeff_t attack;
		coeff_t rel;
		coeff_t lerp;
		coeff_t decay;
	} coeffs_t;

	typedef enum logic [1:0] {
		REG_ATTACK  = 2'd0,
		REG_RELEASE = 2'd1,
		REG_LERP    = 2'd2,
		REG_DECAY   = 2'd3
	} reg_idx_t;

	localparam coeff_t ATTACK_RST  = 16'd39322;
	localparam coeff_t RELEASE_RST = 16'd6226;
	localparam coeff_t LERP_RST    = 16'd22938;
	localparam coeff_t DECAY_RST   = 16'd63570;

endpackage

// File: hdl/sbb_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbb_cfg_regs
// APB register file holding the four ballistics coefficients.
// ----------------------------------------------------------------------------
module sbb_cfg_regs import sbb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output coeffs_t           coeffs
);

	coeffs_t  coeffs_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign coeffs = coeffs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeffs_q.attack <= ATTACK_RST;
			coeffs_q.rel    <= RELEASE_RST;
			coeffs_q.lerp   <= LERP_RST;
			coeffs_q.decay  <= DECAY_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_ATTACK:  coeffs_q.attack <= pwdata[COEFF_W-1:0];
				REG_RELEASE: coeffs_q.rel    <= pwdata[COEFF_W-1:0];
				REG_LERP:    coeffs_q.lerp   <= pwdata[COEFF_W-1:0];
				REG_DECAY:   coeffs_q.decay  <= pwdata[COEFF_W-1:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ATTACK:  prdata = {{(APB_DW-COEFF_W){1'b0}}, coeffs_q.attack};
			REG_RELEASE: prdata = {{(APB_DW-COEFF_W){1'b0}}, coeffs_q.rel};
			REG_LERP:    prdata = {{(APB_DW-COEFF_W){1'b0}}, coeffs_q.lerp};
			REG_DECAY:   prdata = {{(APB_DW-COEFF_W){1'b0}}, coeffs_q.decay};
			default:     prdata = '0;
		endcase
	end

endmodule

// File: hdl/spectrum_bin_ballistics.sv
`timescale 1ns / 1ps
// Pipeline: input accept, then stages for read and smoothing multiply, smoothing add,
// display multiply, display add and peak hold, then the registered result.
// Throughput: one item per cycle unless the output stalls; the bin memory has one read and one write port.
// A bin that repeats within four items of itself stalls s_tready until the earlier
// write-back lands (read-modify-write interlock on the bin memory).
// Reset: coefficients to defaults, all bin valid bits cleared (entries read as zero),
// no clearing pass; the block is ready to accept items as soon as reset is released.
// ----------------------------------------------------------------------------
// spectrum_bin_ballistics
// Per-bin attack/release smoothing, display lerp and decaying peak hold.
// ----------------------------------------------------------------------------
module spectrum_bin_ballistics import sbb_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// APB configuration
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_AW-1:0]      paddr,
	input  logic [APB_DW-1:0]      pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready,
	// input items
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // [5:0] bin_index, [21:6] target_level
	// result items
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata   // [5:0] bin_out, [21:6] display_level,
	                                         // [37:22] peak_level
);

	coeffs_t coeffs;

	sbb_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coeffs  (coeffs)
	);

	// Bin memory: one entry holds {peak, display, smoothed}.
	logic [ENTRY_W-1:0] mem [NUM_BINS];
	logic [NUM_BINS-1:0] vld_q;

	// Input decode
	logic [BIN_W-1:0]  in_bin;
	logic [ADDR_W-1:0] in_addr;
	level_t            in_tgt;
	logic              in_acc;
	logic              adv;
	logic              hazard;

	assign in_bin  = s_tdata[BIN_W-1:0];
	assign in_addr = in_bin[ADDR_W-1:0];
	assign in_tgt  = s_tdata[BIN_W +: LEVEL_BITS];

	// Pipeline registers
	logic               v_s1, v_s2, v_s3, v_s4;
	logic [BIN_W-1:0]   bin_s1, bin_s2, bin_s3, bin_s4;
	level_t             tgt_s1;
	logic [ENTRY_W-1:0] rd_data_s1;
	logic               rd_vld_s1;
	level_t             sm_s2, disp_s2, peak_s2;
	logic               up_s2;
	logic [PROD_W-1:0]  prod1_s2, dprod_s2;
	level_t             sm_s3, disp_s3, peak_s3, decayed_s3;
	level_t             sm_s4, disp_s4, peak_s4, decayed_s4;
	logic               ge_s4;
	logic [PROD_W-1:0]  prod2_s4;

	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	// Whole pipe moves together when the output register can take a result.
	assign adv = !out_valid_q || m_tready;

	// Any in-flight item with the same entry has not written back yet.
	assign hazard = (v_s1 && (bin_s1[ADDR_W-1:0] == in_addr)) ||
	                (v_s2 && (bin_s2[ADDR_W-1:0] == in_addr)) ||
	                (v_s3 && (bin_s3[ADDR_W-1:0] == in_addr)) ||
	                (v_s4 && (bin_s4[ADDR_W-1:0] == in_addr));

	assign s_tready = adv && !hazard;
	assign in_acc   = s_tvalid && s_tready;

	// Stage 1: old values (unwritten entry reads as zero), smoothing and peak decay multiplies.
	level_t            old_sm, old_disp, old_peak;
	logic              up_c;
	level_t            mag1_c;
	coeff_t            coef1_c;
	logic [PROD_W-1:0] prod1_c, dprod_c;

	always_comb begin
		old_sm   = rd_vld_s1 ? rd_data_s1[0 +: LEVEL_BITS] : '0;
		old_disp = rd_vld_s1 ? rd_data_s1[LEVEL_BITS +: LEVEL_BITS] : '0;
		old_peak = rd_vld_s1 ? rd_data_s1[2*LEVEL_BITS +: LEVEL_BITS] : '0;
		// equal target gives a zero step either way
		up_c     = tgt_s1 >= old_sm;
		coef1_c  = up_c ? coeffs.attack : coeffs.rel;
		mag1_c   = up_c ? (tgt_s1 - old_sm) : (old_sm - tgt_s1);
		prod1_c  = PROD_W'(mag1_c) * PROD_W'(coef1_c);
		dprod_c  = PROD_W'(old_peak) * PROD_W'(coeffs.decay);
	end

	// Stage 2: finish smoothed level and decayed peak; falling step rounds the magnitude up.
	level_t sm_new_c, decayed_c, step1_dn_c;

	always_comb begin
		step1_dn_c = prod1_s2[PROD_W-1:COEFF_W] + LEVEL_BITS'(|prod1_s2[COEFF_W-1:0]);
		sm_new_c   = up_s2 ? (sm_s2 + prod1_s2[PROD_W-1:COEFF_W]) : (sm_s2 - step1_dn_c);
		decayed_c  = dprod_s2[PROD_W-1:COEFF_W];
	end

	// Stage 3: display lerp multiply.
	logic              ge_c;
	level_t            mag2_c;
	logic [PROD_W-1:0] prod2_c;

	always_comb begin
		ge_c    = sm_s3 >= disp_s3;
		mag2_c  = ge_c ? (sm_s3 - disp_s3) : (disp_s3 - sm_s3);
		prod2_c = PROD_W'(mag2_c) * PROD_W'(coeffs.lerp);
	end

	// Stage 4: display level, peak hold, write-back.
	level_t            disp_new_c, peak_new_c, step2_dn_c;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;

	always_comb begin
		step2_dn_c = prod2_s4[PROD_W-1:COEFF_W] + LEVEL_BITS'(|prod2_s4[COEFF_W-1:0]);
		disp_new_c = ge_s4 ? (disp_s4 + prod2_s4[PROD_W-1:COEFF_W]) : (disp_s4 - step2_dn_c);
		if (disp_new_c >= peak_s4) begin
			peak_new_c = disp_new_c;
		end else begin
			peak_new_c = (decayed_s4 > disp_new_c) ? decayed_s4 : disp_new_c;
		end
	end

	assign wr_en   = adv && v_s4;
	assign wr_addr = bin_s4[ADDR_W-1:0];

	// Memory: registered read on accept, write at the end of stage 4.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_data_s1 <= mem[in_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= {peak_new_c, disp_new_c, sm_s4};
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
			rd_vld_s1   <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (in_acc) begin
				rd_vld_s1 <= vld_q[in_addr];
			end
			if (adv) begin
				v_s1        <= in_acc;
				v_s2        <= v_s1;
				v_s3        <= v_s2;
				v_s4        <= v_s3;
				out_valid_q <= v_s4;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			bin_s1 <= in_bin;
			tgt_s1 <= in_tgt;
		end
		if (adv) begin
			bin_s2     <= bin_s1;
			sm_s2      <= old_sm;
			disp_s2    <= old_disp;
			peak_s2    <= old_peak;
			up_s2      <= up_c;
			prod1_s2   <= prod1_c;
			dprod_s2   <= dprod_c;

			bin_s3     <= bin_s2;
			sm_s3      <= sm_new_c;
			disp_s3    <= disp_s2;
			peak_s3    <= peak_s2;
			decayed_s3 <= decayed_c;

			bin_s4     <= bin_s3;
			sm_s4      <= sm_s3;
			disp_s4    <= disp_s3;
			peak_s4    <= peak_s3;
			decayed_s4 <= decayed_s3;
			ge_s4      <= ge_c;
			prod2_s4   <= prod2_c;

			out_data_q <= {{(OUT_TDATA_W-BIN_W-2*LEVEL_BITS){1'b0}},
			               peak_new_c, disp_new_c, bin_s4};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef SYNTH
	// Peak hold never sits below the display level it reports.
	a_peak_ge_disp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q[BIN_W+LEVEL_BITS +: LEVEL_BITS] >=
		                 out_data_q[BIN_W +: LEVEL_BITS]))
		else $error("peak below display level");

	// No read of an entry in the same cycle it is written back.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && v_s4) |-> (in_addr != wr_addr))
		else $error("read of entry under write-back");

	// A finished stage 4 item reaches the output register.
	a_s4_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && adv) |=> out_valid_q)
		else $error("stage 4 item lost");

	// A written entry is marked valid from then on.
	a_wr_sets_vld: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> vld_q[$past(wr_addr)])
		else $error("valid bit not set after write-back");
`endif

endmodule
